// ----- sv/frwa_pkg.sv -----
package frwa_pkg;

  // Field and register widths
  localparam int FrameW  = 16;
  localparam int RateW   = 10;
  localparam int ThreshW = 16;
  localparam int CountW  = 6;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgThreshIdx = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCountIdx  = 2'd1;

  // Register reset values
  localparam logic [ThreshW-1:0] ThreshReset = 16'd8;
  localparam logic [CountW-1:0]  CountReset  = 6'd4;

  // Rate arithmetic
  localparam int RateScale = 1000;
  localparam int FastRate  = 500;

  localparam int DefWindowSamples = 32;

endpackage

// ----- sv/frwa_ram.sv -----
module frwa_ram #(
  parameter int Width = 10,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/frwa_div.sv -----
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module frwa_div #(
  parameter int Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);

  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [Width:0] trial;
  logic [Width:0] diff;
  logic           fits;

  assign trial = {rem_q, quo_q[Width-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[Width-1:0] : trial[Width-1:0];
      quo_d = {quo_q[Width-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/frame_rate_window_average_core.sv -----
// Per item: instant rate division (skipped for a zero frame time), then mean frame time
// division (skipped for the first item, a rate of 500 or more, or an empty window), then
// N ring insertions: WindowSamples for the first item, else 1 at a fast rate or near the
// mean, else the count register (none if 0). DivW = 16 at the default window of 32. One
// item at a time, taken once the last result is registered; up to two bit-serial divides.
// Reset: asynchronous, active low; clears sum, slot, primed and handshakes, no clearing pass.
module frame_rate_window_average_core #(
  parameter int WindowSamples = frwa_pkg::DefWindowSamples
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frwa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [frwa_pkg::CfgDataW-1:0] cfg_data_i,
  // frame time input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [frwa_pkg::FrameW-1:0]   frame_ms_i,
  // mean rate output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [frwa_pkg::RateW-1:0]    mean_rate_o
);

  localparam int RateW   = frwa_pkg::RateW;
  localparam int FrameW  = frwa_pkg::FrameW;
  localparam int ThreshW = frwa_pkg::ThreshW;
  localparam int CountW  = frwa_pkg::CountW;

  // Window sum never exceeds RateScale * WindowSamples.
  localparam int MeanNum  = frwa_pkg::RateScale * WindowSamples;
  localparam int SumW     = $clog2(MeanNum + 1);
  localparam int DivW     = (SumW > FrameW) ? SumW : FrameW;
  localparam int SlotW    = $clog2(WindowSamples);
  localparam int MaxCount = (1 << CountW) - 1;
  localparam int MaxTimes = (WindowSamples > MaxCount) ? WindowSamples : MaxCount;
  localparam int TimesW   = $clog2(MaxTimes + 1);

  // sum / WindowSamples as a multiply by the rounded-up reciprocal; exact for any
  // SumW-bit sum with a shift of SumW + clog2(WindowSamples).
  localparam int RecipShift = SumW + SlotW;
  localparam int RecipW     = SumW + 2;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((1 << RecipShift) + WindowSamples - 1) / WindowSamples);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE,       // instant rate division
    S_DECIDE,     // pick the insertion count
    S_MEAN,       // mean frame time division
    S_READ,       // first ring read of the insertion run
    S_INSERT,     // read-modify-write, one slot per cycle
    S_PRIME,      // first item: fill the ring, no reads needed
    S_OUT_HOLD    // wait for the output register to free up
  } state_e;

  state_e             state_q, state_d;
  logic [FrameW-1:0]  frame_q, frame_d;
  logic [RateW-1:0]   rate_q, rate_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [TimesW-1:0]  times_q, times_d;
  logic               primed_q, primed_d;
  logic [ThreshW-1:0] thresh_q, thresh_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic [RateW-1:0]   mean_rate_q, mean_rate_d;

  logic [SlotW-1:0] slot_nxt;
  logic             ram_we;
  logic [SlotW-1:0] ram_raddr;
  logic [RateW-1:0] ram_rdata;

  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [DivW-1:0] div_divisor;
  logic            div_done;
  logic [DivW-1:0] div_quo;

  logic [DivW-1:0] frame_ext;
  logic [DivW-1:0] mean_diff;
  logic            near_mean;

  logic [SumW+RecipW-1:0] mean_prod;

  assign slot_nxt = (slot_q == SlotW'(WindowSamples - 1)) ? '0 : slot_q + 1'b1;

  // |mean frame time - frame time| against the threshold
  assign frame_ext = DivW'(frame_q);
  assign mean_diff = (div_quo >= frame_ext) ? div_quo - frame_ext : frame_ext - div_quo;
  assign near_mean = mean_diff <= DivW'(thresh_q);

  assign mean_prod = {{RecipW{1'b0}}, sum_q} * {{SumW{1'b0}}, RecipMul};

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign mean_rate_o = mean_rate_q;

  always_comb begin
    state_d      = state_q;
    frame_d      = frame_q;
    rate_d       = rate_q;
    sum_d        = sum_q;
    slot_d       = slot_q;
    times_d      = times_q;
    primed_d     = primed_q;
    thresh_d     = thresh_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    mean_rate_d  = mean_rate_q;
    ram_we       = 1'b0;
    ram_raddr    = slot_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    // Register writes; unknown indexes are dropped.
    if (cfg_valid_i) begin
      if (cfg_index_i == frwa_pkg::CfgThreshIdx) begin
        thresh_d = cfg_data_i[ThreshW-1:0];
      end else if (cfg_index_i == frwa_pkg::CfgCountIdx) begin
        count_d = cfg_data_i[CountW-1:0];
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          frame_d = frame_ms_i;
          if (frame_ms_i == '0) begin
            // under one millisecond: rate pinned to full scale
            rate_d  = RateW'(frwa_pkg::RateScale);
            state_d = S_DECIDE;
          end else begin
            div_start    = 1'b1;
            div_dividend = DivW'(frwa_pkg::RateScale);
            div_divisor  = DivW'(frame_ms_i);
            state_d      = S_RATE;
          end
        end
      end
      S_RATE: begin
        if (div_done) begin
          rate_d  = div_quo[RateW-1:0];
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!primed_q) begin
          primed_d = 1'b1;
          times_d  = TimesW'(WindowSamples);
          state_d  = S_PRIME;
        end else if (rate_q >= RateW'(frwa_pkg::FastRate)) begin
          times_d = TimesW'(1);
          state_d = S_READ;
        end else if (sum_q == '0) begin
          // empty window: treated as beyond the threshold
          times_d = TimesW'(count_q);
          state_d = (count_q == '0) ? S_OUT_HOLD : S_READ;
        end else begin
          div_start    = 1'b1;
          div_dividend = DivW'(MeanNum);
          div_divisor  = DivW'(sum_q);
          state_d      = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          times_d = near_mean ? TimesW'(1) : TimesW'(count_q);
          state_d = (near_mean || count_q != '0) ? S_READ : S_OUT_HOLD;
        end
      end
      S_READ: begin
        state_d = S_INSERT;
      end
      S_INSERT: begin
        // rdata holds the slot being replaced; the next slot is read meanwhile.
        // With at least two slots the read never hits the slot written this cycle.
        ram_we    = 1'b1;
        ram_raddr = slot_nxt;
        sum_d     = sum_q - SumW'(ram_rdata) + SumW'(rate_q);
        slot_d    = slot_nxt;
        times_d   = times_q - 1'b1;
        if (times_q == TimesW'(1)) begin
          state_d = S_OUT_HOLD;
        end
      end
      S_PRIME: begin
        // ring not yet filled: nothing to subtract, every slot is overwritten
        ram_we  = 1'b1;
        sum_d   = sum_q + SumW'(rate_q);
        slot_d  = slot_nxt;
        times_d = times_q - 1'b1;
        if (times_q == TimesW'(1)) begin
          state_d = S_OUT_HOLD;
        end
      end
      S_OUT_HOLD: begin
        // window sum is final here; mean comes straight from the reciprocal product
        if (!out_valid_q || out_ready_i) begin
          mean_rate_d = mean_prod[RecipShift +: RateW];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_q     <= '0;
      rate_q      <= '0;
      sum_q       <= '0;
      slot_q      <= '0;
      times_q     <= '0;
      primed_q    <= 1'b0;
      thresh_q    <= frwa_pkg::ThreshReset;
      count_q     <= frwa_pkg::CountReset;
      out_valid_q <= 1'b0;
      mean_rate_q <= '0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      rate_q      <= rate_d;
      sum_q       <= sum_d;
      slot_q      <= slot_d;
      times_q     <= times_d;
      primed_q    <= primed_d;
      thresh_q    <= thresh_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      mean_rate_q <= mean_rate_d;
    end
  end

  frwa_ram #(
    .Width(RateW),
    .Depth(WindowSamples)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(rate_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  frwa_div #(
    .Width(DivW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

endmodule
